// ----- hdl/epp_pkg.sv -----
package epp_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_EXPERTS = 1'b0,
        CFG_TOP     = 1'b1
    } cfg_idx_t;

    // input and result field widths
    localparam int LAYER_W   = 5;
    localparam int ID_W      = 10;
    localparam int PRED_W    = 6;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 16;

    // register reset values and the request limit
    localparam logic [CFG_W-1:0] EXPERTS_RST = 7'd64;
    localparam logic [CFG_W-1:0] TOP_RST     = 7'd8;
    localparam int               RESULT_CAP  = 64;

    // saturating pair count ceiling
    localparam logic [CNT_W-1:0] COUNT_CEIL = 16'hFFFF;

    // neighbour offsets around a recent expert, in scan order
    localparam int OFF_NEAR = 1;
    localparam int OFF_FAR  = 2;
    typedef logic signed [2:0] offset_t;
    localparam offset_t LOC_OFFS [4] = '{-3'(OFF_FAR), -3'(OFF_NEAR),
                                         3'(OFF_NEAR), 3'(OFF_FAR)};

endpackage

// ----- hdl/epp_ram.sv -----
module epp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/expert_prefetch_predictor_unit.sv -----
// Expert prefetch predictor. Expert ids stream in on the slave side, one per
// transfer, and collect in a list until a transfer with tlast; that transfer's
// tuser (0 = update, 1 = predict) and layer apply to the whole list. An update
// raises saturating pair counts between in-range listed experts and moves each
// listed id to the front of the layer's recent list; it gives no result. A
// predict gives one result per predicted expert (tlast on the last one), or a
// single result with tuser = 1 when nothing was found. Pair counts live in one
// memory of MAX_LAYERS*MAX_EXPERTS*MAX_EXPERTS words read and written through
// a single port pair, so all count work is serialized through that memory:
// after reset a clearing pass zeroes every word before the first transfer is
// taken. An update reads and writes back both cells of each in-range pair of
// the list, then loads, reorders and writes back the layer's recent list. A
// predict scans the count row of each listed expert for its partners, then
// scans the neighbours of each entry of the layer's recent list.
module expert_prefetch_predictor_unit
    import epp_pkg::*;
#(
    parameter int MAX_LAYERS   = 32,
    parameter int MAX_EXPERTS  = 64,
    parameter int RECENT_DEPTH = 8,
    parameter int MAX_LIST     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // layer[4:0], expert[14:5], zero[15]
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // list_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pred_layer[4:0], pred_expert[10:5], zero[15:11]
    output logic        m_tuser,   // none_found
    output logic        m_tlast,   // final_res
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int XW    = $clog2(MAX_EXPERTS);
    localparam int NW    = $clog2(MAX_EXPERTS + 1);
    localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int PD    = MAX_LAYERS * MAX_EXPERTS * MAX_EXPERTS;
    localparam int PAW   = $clog2(PD);
    localparam int RD    = RECENT_DEPTH;
    localparam int RKW   = (RD > 1) ? $clog2(RD) : 1;
    localparam int RLW   = $clog2(RD + 1);
    localparam int RDEP  = MAX_LAYERS * RD;
    localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;
    localparam int MLW   = $clog2(MAX_LIST + 1);
    localparam int MIW   = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int TW    = CFG_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        U_ROW, U_COL, U_RD, U_WR,
        R_RD, R_CAP, U_FRONT, R_WB,
        P_MARK, P_ROW, P_SEL, P_SCAN, P_PICK,
        L_INIT, L_STEP, P_END
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       eiu_reg;
    logic [CFG_W-1:0]       top_reg;
    logic [ID_W-1:0]        list_buf [MAX_LIST];
    logic [MLW-1:0]         len_reg;
    logic                   mode_reg;
    logic [LAYER_W-1:0]     layer_reg;
    logic [MLW-1:0]         i_reg;
    logic [MLW-1:0]         j_reg;
    logic [XW-1:0]          a_reg;
    logic [XW-1:0]          b_reg;
    logic                   dir_reg;
    logic [PAW-1:0]         clr_reg;
    logic [ID_W-1:0]        rec_reg [RD];
    logic [RLW-1:0]         rlen_reg [MAX_LAYERS];
    logic [RLW-1:0]         cur_len_reg;
    logic [RKW-1:0]         rk_reg;
    logic [MAX_EXPERTS-1:0] seen_reg;
    logic [MAX_EXPERTS-1:0] loc_seen_reg;
    logic [TW-1:0]          cnt_reg;
    logic [TW-1:0]          s_reg;
    logic [NW-1:0]          c_reg;
    logic                   cv_reg;
    logic [XW-1:0]          cd_reg;
    logic                   best_ok_reg;
    logic [XW-1:0]          best_reg;
    logic [CNT_W-1:0]       bestc_reg;
    logic [RLW-1:0]         li_reg;
    logic [1:0]             k_reg;
    logic                   pend_valid_reg;
    logic [PRED_W-1:0]      pend_reg;
    logic                   m_tvalid_reg;
    logic [LAYER_W-1:0]     o_layer_reg;
    logic [PRED_W-1:0]      o_expert_reg;
    logic                   o_none_reg;
    logic                   o_final_reg;

    logic [NW-1:0]          n_lim;
    logic [TW-1:0]          top_lim;
    logic [TW-1:0]          half_lim;
    logic [LW-1:0]          lidx;
    logic [MLW-1:0]         lsel;
    logic [ID_W-1:0]        list_dat;
    logic                   list_in_n;
    logic                   in_acc;
    logic                   out_free;
    logic                   emit_ok;
    logic                   layer_ok;
    logic                   loc_emit;
    logic                   out_load;

    logic                   pc_we;
    logic [PAW-1:0]         pc_waddr;
    logic [CNT_W-1:0]       pc_wdata;
    logic                   pc_re;
    logic [PAW-1:0]         pc_raddr;
    logic [CNT_W-1:0]       pc_rdata;
    logic [PAW-1:0]         bump_addr;
    logic [PAW-1:0]         scan_addr;

    logic                   rc_we;
    logic [RAW-1:0]         rc_addr;
    logic [ID_W-1:0]        rc_rdata;

    logic [ID_W-1:0]        tf_rec [RD];
    logic [RLW-1:0]         tf_len;
    logic                   tf_hit;
    logic [RLW-1:0]         tf_pos;

    logic [MAX_EXPERTS-1:0] rec_mask;

    logic signed [ID_W+1:0] nb;
    logic                   nb_ok;
    logic [XW-1:0]          nb_id;

    // limits from the configuration registers
    assign n_lim    = ({25'd0, eiu_reg} > 32'(MAX_EXPERTS)) ? NW'(MAX_EXPERTS)
                                                            : NW'(eiu_reg);
    assign top_lim  = (32'(top_reg) > 32'(RESULT_CAP)) ? TW'(RESULT_CAP) : top_reg;
    assign half_lim = top_lim >> 1;
    assign lidx     = LW'(layer_reg);
    assign layer_ok = ({27'd0, layer_reg} < 32'(MAX_LAYERS));

    // list buffer read port
    assign lsel      = (state_reg == U_COL) ? j_reg : i_reg;
    assign list_dat  = list_buf[lsel[MIW-1:0]];
    assign list_in_n = ({1'b0, list_dat} < (ID_W+1)'(n_lim));

    // handshakes
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, o_expert_reg, o_layer_reg};
    assign m_tuser  = o_none_reg;
    assign m_tlast  = o_final_reg;

    // pair count addressing
    assign bump_addr = dir_reg
        ? PAW'((PAW'(lidx) * PAW'(MAX_EXPERTS) + PAW'(b_reg)) * PAW'(MAX_EXPERTS)
               + PAW'(a_reg))
        : PAW'((PAW'(lidx) * PAW'(MAX_EXPERTS) + PAW'(a_reg)) * PAW'(MAX_EXPERTS)
               + PAW'(b_reg));
    assign scan_addr =
        PAW'((PAW'(lidx) * PAW'(MAX_EXPERTS) + PAW'(a_reg)) * PAW'(MAX_EXPERTS)
             + PAW'(XW'(c_reg)));

    assign pc_we    = (state_reg == S_CLEAR) || (state_reg == U_WR);
    assign pc_waddr = (state_reg == S_CLEAR) ? clr_reg : bump_addr;
    assign pc_wdata = (state_reg == S_CLEAR) ? '0
                    : (pc_rdata == COUNT_CEIL) ? pc_rdata : pc_rdata + 1'b1;
    assign pc_re    = (state_reg == U_RD) || ((state_reg == P_SCAN) && (c_reg < n_lim));
    assign pc_raddr = (state_reg == U_RD) ? bump_addr : scan_addr;

    epp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (PD)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (pc_we),
        .wr_addr (pc_waddr),
        .wr_data (pc_wdata),
        .rd_en   (pc_re),
        .rd_addr (pc_raddr),
        .rd_data (pc_rdata)
    );

    // recent list memory, one row of RECENT_DEPTH words per layer
    assign rc_we   = (state_reg == R_WB);
    assign rc_addr = RAW'(RAW'(lidx) * RAW'(RD) + RAW'(rk_reg));

    epp_ram #(
        .WIDTH (ID_W),
        .DEPTH (RDEP)
    ) u_recent_ram (
        .clk     (clk),
        .wr_en   (rc_we),
        .wr_addr (rc_addr),
        .wr_data (rec_reg[rk_reg]),
        .rd_en   (state_reg == R_RD),
        .rd_addr (rc_addr),
        .rd_data (rc_rdata)
    );

    // move one id to the front of the loaded recent list
    always_comb
    begin
        tf_hit = 1'b0;
        tf_pos = (cur_len_reg == RLW'(RD)) ? RLW'(RD - 1) : cur_len_reg;
        for (int k = RD - 1; k >= 0; k--)
        begin
            if ((RLW'(k) < cur_len_reg) && (rec_reg[k] == list_dat))
            begin
                tf_hit = 1'b1;
                tf_pos = RLW'(k);
            end
        end
        for (int k = 0; k < RD; k++)
        begin
            if (k == 0)
            begin
                tf_rec[k] = list_dat;
            end
            else if (RLW'(k) <= tf_pos)
            begin
                tf_rec[k] = rec_reg[k - 1];
            end
            else
            begin
                tf_rec[k] = rec_reg[k];
            end
        end
        if (tf_hit || (cur_len_reg == RLW'(RD)))
        begin
            tf_len = cur_len_reg;
        end
        else
        begin
            tf_len = cur_len_reg + 1'b1;
        end
    end

    // in-range recent ids, never their own neighbours
    always_comb
    begin
        rec_mask = '0;
        for (int r = 0; r < RD; r++)
        begin
            if ((RLW'(r) < cur_len_reg)
                && ({22'd0, rec_reg[r]} < 32'(MAX_EXPERTS)))
            begin
                rec_mask[XW'(rec_reg[r])] = 1'b1;
            end
        end
    end

    // neighbour of a recent expert
    assign nb    = $signed({2'b00, rec_reg[li_reg[RKW-1:0]]})
                 + (ID_W+2)'(LOC_OFFS[k_reg]);
    assign nb_ok = !nb[ID_W+1] && (nb < $signed((ID_W+2)'(n_lim)));
    assign nb_id = XW'(nb);

    // result register loads
    assign loc_emit = (li_reg < cur_len_reg) && nb_ok && !loc_seen_reg[nb_id]
                   && !seen_reg[nb_id] && (cnt_reg < top_lim);
    assign out_load = ((state_reg == P_PICK) && best_ok_reg && pend_valid_reg && emit_ok)
                   || ((state_reg == L_STEP) && loc_emit && pend_valid_reg && emit_ok)
                   || ((state_reg == P_END) && out_free);

    // list buffer writes
    always_ff @(posedge clk)
    begin
        if (in_acc && (len_reg < MLW'(MAX_LIST)))
        begin
            list_buf[len_reg[MIW-1:0]] <= s_tdata[14:5];
        end
    end

    // loaded recent list
    always_ff @(posedge clk)
    begin
        if (state_reg == R_CAP)
        begin
            rec_reg[rk_reg] <= rc_rdata;
        end
        else if ((state_reg == U_FRONT) && (i_reg < len_reg))
        begin
            rec_reg <= tf_rec;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= EXPERTS_RST;
            top_reg <= TOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPERTS: eiu_reg <= cfg_data;
                CFG_TOP:     top_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // control sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            len_reg        <= '0;
            mode_reg       <= 1'b0;
            layer_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            dir_reg        <= 1'b0;
            cur_len_reg    <= '0;
            rk_reg         <= '0;
            seen_reg       <= '0;
            loc_seen_reg   <= '0;
            cnt_reg        <= '0;
            s_reg          <= '0;
            c_reg          <= '0;
            cv_reg         <= 1'b0;
            cd_reg         <= '0;
            best_ok_reg    <= 1'b0;
            best_reg       <= '0;
            bestc_reg      <= '0;
            li_reg         <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            o_layer_reg    <= '0;
            o_expert_reg   <= '0;
            o_none_reg     <= 1'b0;
            o_final_reg    <= 1'b0;
            for (int l = 0; l < MAX_LAYERS; l++)
            begin
                rlen_reg[l] <= '0;
            end
        end
        else
        begin
            // result valid: set on a load, dropped once taken
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);

            unique case (state_reg)
                // zero the pair counts after reset
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PAW'(PD - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                // collect the list
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (len_reg < MLW'(MAX_LIST))
                        begin
                            len_reg <= len_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            mode_reg       <= s_tuser;
                            layer_reg      <= s_tdata[4:0];
                            i_reg          <= '0;
                            cnt_reg        <= '0;
                            seen_reg       <= '0;
                            pend_valid_reg <= 1'b0;
                            if ({27'd0, s_tdata[4:0]} >= 32'(MAX_LAYERS))
                            begin
                                if (s_tuser)
                                begin
                                    state_reg <= P_END;
                                end
                                else
                                begin
                                    len_reg <= '0;
                                end
                            end
                            else
                            begin
                                state_reg <= s_tuser ? P_MARK : U_ROW;
                            end
                        end
                    end
                end

                // pair count update, row by row
                U_ROW:
                begin
                    if (i_reg >= len_reg)
                    begin
                        rk_reg      <= '0;
                        cur_len_reg <= rlen_reg[lidx];
                        state_reg   <= R_RD;
                    end
                    else if (list_in_n)
                    begin
                        a_reg     <= XW'(list_dat);
                        j_reg     <= i_reg + 1'b1;
                        state_reg <= U_COL;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end

                U_COL:
                begin
                    if (j_reg >= len_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= U_ROW;
                    end
                    else if (list_in_n)
                    begin
                        b_reg     <= XW'(list_dat);
                        dir_reg   <= 1'b0;
                        state_reg <= U_RD;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end

                U_RD:
                begin
                    state_reg <= U_WR;
                end

                // write back the bumped count, then the mirrored cell
                U_WR:
                begin
                    if (!dir_reg)
                    begin
                        dir_reg   <= 1'b1;
                        state_reg <= U_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= U_COL;
                    end
                end

                // load the layer's recent list
                R_RD:
                begin
                    state_reg <= R_CAP;
                end

                R_CAP:
                begin
                    if (rk_reg == RKW'(RD - 1))
                    begin
                        rk_reg <= '0;
                        i_reg  <= '0;
                        li_reg <= '0;
                        k_reg  <= '0;
                        state_reg <= mode_reg ? L_INIT : U_FRONT;
                    end
                    else
                    begin
                        rk_reg    <= rk_reg + 1'b1;
                        state_reg <= R_RD;
                    end
                end

                // move listed ids to the front
                U_FRONT:
                begin
                    if (i_reg < len_reg)
                    begin
                        cur_len_reg <= tf_len;
                        i_reg       <= i_reg + 1'b1;
                    end
                    else
                    begin
                        rk_reg    <= '0;
                        state_reg <= R_WB;
                    end
                end

                R_WB:
                begin
                    if (rk_reg == RKW'(RD - 1))
                    begin
                        rlen_reg[lidx] <= cur_len_reg;
                        len_reg        <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        rk_reg <= rk_reg + 1'b1;
                    end
                end

                // mark listed experts as seen
                P_MARK:
                begin
                    if (i_reg >= len_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= P_ROW;
                    end
                    else
                    begin
                        if ({22'd0, list_dat} < 32'(MAX_EXPERTS))
                        begin
                            seen_reg[XW'(list_dat)] <= 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end

                // partner choice per listed expert
                P_ROW:
                begin
                    if ((i_reg >= len_reg) || (cnt_reg >= top_lim))
                    begin
                        rk_reg      <= '0;
                        cur_len_reg <= rlen_reg[lidx];
                        state_reg   <= R_RD;
                    end
                    else if (list_in_n)
                    begin
                        a_reg     <= XW'(list_dat);
                        s_reg     <= '0;
                        state_reg <= P_SEL;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end

                P_SEL:
                begin
                    if ((s_reg >= half_lim) || (cnt_reg >= top_lim))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= P_ROW;
                    end
                    else
                    begin
                        c_reg       <= '0;
                        cv_reg      <= 1'b0;
                        best_ok_reg <= 1'b0;
                        bestc_reg   <= '0;
                        state_reg   <= P_SCAN;
                    end
                end

                // stream the count row, keep the strongest unseen partner
                P_SCAN:
                begin
                    if (c_reg < n_lim)
                    begin
                        c_reg  <= c_reg + 1'b1;
                        cd_reg <= XW'(c_reg);
                        cv_reg <= 1'b1;
                    end
                    else
                    begin
                        cv_reg <= 1'b0;
                    end
                    if (cv_reg && (pc_rdata > bestc_reg) && !seen_reg[cd_reg])
                    begin
                        bestc_reg   <= pc_rdata;
                        best_reg    <= cd_reg;
                        best_ok_reg <= 1'b1;
                    end
                    if ((c_reg >= n_lim) && !cv_reg)
                    begin
                        state_reg <= P_PICK;
                    end
                end

                P_PICK:
                begin
                    if (!best_ok_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= P_ROW;
                    end
                    else if (emit_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            o_layer_reg  <= layer_reg;
                            o_expert_reg <= pend_reg;
                            o_none_reg   <= 1'b0;
                            o_final_reg  <= 1'b0;
                        end
                        pend_valid_reg     <= 1'b1;
                        pend_reg           <= PRED_W'(best_reg);
                        seen_reg[best_reg] <= 1'b1;
                        cnt_reg            <= cnt_reg + 1'b1;
                        s_reg              <= s_reg + 1'b1;
                        state_reg          <= P_SEL;
                    end
                end

                // recent ids are never their own neighbours
                L_INIT:
                begin
                    loc_seen_reg <= rec_mask;
                    state_reg    <= L_STEP;
                end

                // neighbours at -2, -1, +1, +2 of each recent id
                L_STEP:
                begin
                    if (li_reg >= cur_len_reg)
                    begin
                        loc_seen_reg <= '0;
                        state_reg    <= P_END;
                    end
                    else if (loc_emit && !emit_ok)
                    begin
                        // wait for the output slot
                    end
                    else
                    begin
                        if (nb_ok && !loc_seen_reg[nb_id])
                        begin
                            loc_seen_reg[nb_id] <= 1'b1;
                            if (!seen_reg[nb_id] && (cnt_reg < top_lim))
                            begin
                                if (pend_valid_reg)
                                begin
                                    o_layer_reg  <= layer_reg;
                                    o_expert_reg <= pend_reg;
                                    o_none_reg   <= 1'b0;
                                    o_final_reg  <= 1'b0;
                                end
                                pend_valid_reg   <= 1'b1;
                                pend_reg         <= PRED_W'(nb_id);
                                seen_reg[nb_id]  <= 1'b1;
                                cnt_reg          <= cnt_reg + 1'b1;
                            end
                        end
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == 2'd3)
                        begin
                            li_reg <= li_reg + 1'b1;
                        end
                    end
                end

                // last result, or the empty marker
                P_END:
                begin
                    if (out_free)
                    begin
                        o_layer_reg    <= layer_reg;
                        o_expert_reg   <= pend_valid_reg ? pend_reg : '0;
                        o_none_reg     <= !pend_valid_reg;
                        o_final_reg    <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        len_reg        <= '0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a pending prediction never outlives its request
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending prediction left in idle");

    // an empty marker always closes its request
    a_none_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty marker without tlast");

    // nothing enters or leaves while the count store is being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!m_tvalid && !s_tready))
        else $error("traffic during clearing pass");

    // count writes only from the clearing pass or the bump write-back
    a_pair_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_WR) |-> ($past(state_reg) == U_RD))
        else $error("count write without its read");

endmodule
